FILE: hdl/sorted_list_rank_access_top_defines.svh
// Assertion macros shared by the sorted list RTL.
`ifndef SORTED_LIST_RANK_ACCESS_TOP_DEFINES_SVH
`define SORTED_LIST_RANK_ACCESS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

FILE: hdl/slra_pkg.sv
// Types and constants shared by the sorted list modules.
`timescale 1ns / 1ps
`default_nettype none

package slra_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 8;
  localparam int PAYLOAD_BITS = 8;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_W-1:0]        rank;
  } req_t;

  typedef struct packed {
    logic                    ok;
    logic [KEY_BITS-1:0]     key_out;
    logic [PAYLOAD_BITS-1:0] payload_out;
    logic [CNT_W-1:0]        count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: hdl/sorted_list_rank_access_top.sv
// Top level of the sorted list with insert by key and read/remove by rank.
`timescale 1ns / 1ps
`default_nettype none
// A request is captured, then dispatched: a failed one goes straight to the
// result, a read waits for the RAM data, a remove moves each entry above the
// removed rank down a slot, and an insert moves each entry with a larger key
// up a slot, then writes the new one. One request is in work at a time; the
// block is ready in the cycle after the result enters the output register.
// Reset clears the entry count and all handshake state; RAM contents persist.

module sorted_list_rank_access_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire slra_pkg::req_t in_req_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      slra_pkg::rsp_t out_rsp_o
);

  import slra_pkg::*;

  // Sequencer to output register.
  logic     res_valid;
  logic     res_ready;
  rsp_t     res;

  // Sequencer to entry RAM.
  mem_req_t mem_req;
  entry_t   mem_rdata;

  // Output register state.
  logic     out_valid_q;
  rsp_t     out_rsp_q;

  slra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Entries held in rank order: rank r sits at address r - 1.
  slra_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: take a new result when empty or when the held one
  // leaves in this cycle; hold it otherwise.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_rsp_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

FILE: hdl/slra_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module slra_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH_P)-1:0] waddr_i,
  input  wire logic [WIDTH_P-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH_P)-1:0] raddr_i,
  output      logic [WIDTH_P-1:0]         rdata_o
);

  logic [WIDTH_P-1:0] mem_q [DEPTH_P];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/slra_ctrl.sv
// Sequencer: walks the entry RAM to insert, read and remove by rank.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_rank_access_top_defines.svh"

module slra_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output      logic                req_ready_o,
  input  wire slra_pkg::req_t      req_i,
  output      logic                res_valid_o,
  input  wire logic                res_ready_i,
  output      slra_pkg::rsp_t      res_o,
  output      slra_pkg::mem_req_t  mem_req_o,
  input  wire slra_pkg::entry_t    mem_rdata_i
);

  import slra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_WALK,
    S_INS_PUT,
    S_RM_WALK,
    S_RD_WAIT,
    S_RESULT
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  rsp_t             rsp_q, rsp_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] occ_q, occ_d;

  entry_t           new_entry;
  logic             rank_ok;
  logic [IDX_W-1:0] pos;

  assign new_entry = '{key: req_q.key, payload: req_q.payload};
  assign rank_ok   = (req_q.rank != '0) && (req_q.rank <= occ_q);
  assign pos       = IDX_W'(req_q.rank - CNT_W'(1));

  // Reads issued in one cycle never target the slot written in the next,
  // so no forwarding is needed around the RAM.
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    idx_d     = idx_q;
    occ_d     = occ_q;
    mem_req_o = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        rsp_d   = '{ok: 1'b0, key_out: '0, payload_out: '0, count: occ_q};
        state_d = S_RESULT;
        case (req_q.opcode)
          OP_INSERT: begin
            if (occ_q != CNT_W'(DEPTH)) begin
              occ_d      = occ_q + CNT_W'(1);
              rsp_d.ok    = 1'b1;
              rsp_d.count = occ_q + CNT_W'(1);
              idx_d      = occ_q[IDX_W-1:0];
              if (occ_q == '0) begin
                state_d = S_INS_PUT;
              end else begin
                mem_req_o.raddr = IDX_W'(occ_q - CNT_W'(1));
                state_d         = S_INS_WALK;
              end
            end
          end
          OP_READ: begin
            if (rank_ok) begin
              rsp_d.ok        = 1'b1;
              mem_req_o.raddr = pos;
              state_d         = S_RD_WAIT;
            end
          end
          OP_REMOVE: begin
            if (rank_ok) begin
              occ_d       = occ_q - CNT_W'(1);
              rsp_d.ok    = 1'b1;
              rsp_d.count = occ_q - CNT_W'(1);
              idx_d       = pos;
              if (req_q.rank != occ_q) begin
                mem_req_o.raddr = pos + IDX_W'(1);
                state_d         = S_RM_WALK;
              end
            end
          end
          default: begin
            state_d = S_RESULT;
          end
        endcase
      end

      // Walk down from the top: shift larger keys up one slot until the
      // slot below holds a key not above the new one.
      S_INS_WALK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        if (mem_rdata_i.key <= req_q.key) begin
          mem_req_o.wdata = new_entry;
          state_d         = S_RESULT;
        end else begin
          mem_req_o.wdata = mem_rdata_i;
          if (idx_q == IDX_W'(1)) begin
            idx_d   = '0;
            state_d = S_INS_PUT;
          end else begin
            idx_d           = idx_q - IDX_W'(1);
            mem_req_o.raddr = idx_q - IDX_W'(2);
          end
        end
      end

      S_INS_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = new_entry;
        state_d         = S_RESULT;
      end

      // Close the gap: move each entry above the removed one down a slot.
      S_RM_WALK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = mem_rdata_i;
        if (CNT_W'(idx_q) + CNT_W'(1) < occ_q) begin
          idx_d           = idx_q + IDX_W'(1);
          mem_req_o.raddr = idx_q + IDX_W'(2);
        end else begin
          state_d = S_RESULT;
        end
      end

      S_RD_WAIT: begin
        rsp_d.key_out     = mem_rdata_i.key;
        rsp_d.payload_out = mem_rdata_i.payload;
        state_d           = S_RESULT;
      end

      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      rsp_q   <= '0;
      idx_q   <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      rsp_q   <= rsp_d;
      idx_q   <= idx_d;
      occ_q   <= occ_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = rsp_q;

  `ASSERT_NEVER(a_occ_range, clk_i, rst_ni, occ_q > CNT_W'(DEPTH), "occupancy above depth")
  `ASSERT_PROP(a_occ_step, clk_i, rst_ni, !$stable(occ_q) |-> $past(state_q == S_DISPATCH), "occupancy changed outside dispatch")
  `ASSERT_NEVER(a_idle_write, clk_i, rst_ni, (state_q == S_IDLE) && mem_req_o.we, "RAM written while idle")
  `ASSERT_PROP(a_fail_zero, clk_i, rst_ni, res_valid_o && !res_o.ok |-> (res_o.key_out == '0) && (res_o.payload_out == '0), "failed request carries data")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the sorted list: a directed request table, then random bursts.
module tb_top;
  import slra_pkg::*;

  // The package names only the three live opcodes; the fourth code must fail.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RAND_REQS   = 850;
  localparam int IDLE_PCT    = 6;
  localparam int HOLD_CYCLES = 300;
  // Leave margin after the last result for the slowest request.
  localparam int TAIL_CYCLES = DEPTH + 8;
  // Longest quiet stretch in a good run is the long hold-off plus one request.
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  // One row of the directed table. Rows with a typed result carry it in want;
  // the others are checked against the list model below.
  typedef struct {
    req_t req;
    int   reps;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_req_i    = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  // Shadow copy of the list: entry r-1 holds rank r.
  logic [KEY_BITS-1:0]     list_keys [DEPTH];
  logic [PAYLOAD_BITS-1:0] list_pays [DEPTH];
  int                      list_count = 0;

  rsp_t     expected_rsps [$];
  dir_row_t dir_rows [$];
  int       err_cnt   = 0;
  bit       steady    = 1'b0;
  int       hold_asks = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_list_rank_access_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Apply one request to the shadow list and return the result it must give.
  function automatic rsp_t list_apply(input req_t r);
    rsp_t rsp;
    int   pos;
    rsp = '0;
    if (r.opcode == OP_INSERT) begin
      if (list_count < DEPTH) begin
        // Walk past every smaller or equal key, so equal keys keep arrival order.
        pos = 0;
        while (pos < list_count && list_keys[pos] <= r.key) pos++;
        for (int i = list_count; i > pos; i--) begin
          list_keys[i] = list_keys[i-1];
          list_pays[i] = list_pays[i-1];
        end
        list_keys[pos] = r.key;
        list_pays[pos] = r.payload;
        list_count++;
        rsp.ok = 1'b1;
      end
    end else if (r.opcode != OP_UNUSED && r.rank != '0 && int'(r.rank) <= list_count) begin
      pos    = int'(r.rank) - 1;
      rsp.ok = 1'b1;
      if (r.opcode == OP_READ) begin
        rsp.key_out     = list_keys[pos];
        rsp.payload_out = list_pays[pos];
      end else if (r.opcode == OP_REMOVE) begin
        // Close the gap left by the removed rank.
        for (int i = pos; i + 1 < list_count; i++) begin
          list_keys[i] = list_keys[i+1];
          list_pays[i] = list_pays[i+1];
        end
        list_count--;
      end
    end
    rsp.count = CNT_W'(list_count);
    return rsp;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                         input logic [PAYLOAD_BITS-1:0] pay, input logic [CNT_W-1:0] rank,
                         input int reps, input bit typed, input logic ok,
                         input logic [KEY_BITS-1:0] kout, input logic [PAYLOAD_BITS-1:0] pout,
                         input logic [CNT_W-1:0] cnt);
    dir_row_t row;
    row.req.opcode       = op;
    row.req.key          = key;
    row.req.payload      = pay;
    row.req.rank         = rank;
    row.reps             = reps;
    row.typed            = typed;
    row.want.ok          = ok;
    row.want.key_out     = kout;
    row.want.payload_out = pout;
    row.want.count       = cnt;
    dir_rows.push_back(row);
  endtask

  // Offer one request, hold it until accepted, then queue its expected result.
  // Valid stays high across back-to-back requests; idle cycles drop it.
  task automatic offer(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = list_apply(r);
    expected_rsps.push_back(typed ? want : pred);
  endtask

  // Result side: stall now and then, and run one long hold-off on request of
  // the stimulus so that the block backs up and stalls its input.
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen   = hold_asks;
      hold_left   = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare every accepted result with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        err_cnt++;
        $error("unexpected result: ok=%0b key_out=%0h payload_out=%0h count=%0d",
               out_rsp_o.ok, out_rsp_o.key_out, out_rsp_o.payload_out, out_rsp_o.count);
      end else begin
        want = expected_rsps.pop_front();
        if (out_rsp_o.ok !== want.ok) begin
          err_cnt++;
          $error("ok: expected %0b, got %0b", want.ok, out_rsp_o.ok);
        end
        if (out_rsp_o.key_out !== want.key_out) begin
          err_cnt++;
          $error("key_out: expected %0h, got %0h", want.key_out, out_rsp_o.key_out);
        end
        if (out_rsp_o.payload_out !== want.payload_out) begin
          err_cnt++;
          $error("payload_out: expected %0h, got %0h", want.payload_out, out_rsp_o.payload_out);
        end
        if (out_rsp_o.count !== want.count) begin
          err_cnt++;
          $error("count: expected %0d, got %0d", want.count, out_rsp_o.count);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  int quiet = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    req_t r;
    rsp_t none;
    mix_e mix;
    int   sent;
    int   burst_left;
    int   key_span;
    int   pick;
    none = '0;

    // Empty list: every read and remove fails, the unused opcode fails.
    add_row(OP_READ,   8'h00, 8'h00, 5'd1,  1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd0);
    add_row(OP_REMOVE, 8'hFF, 8'hFF, 5'd1,  1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd0);
    add_row(OP_UNUSED, 8'h00, 8'h00, 5'd0,  1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd0);
    // Build [00/FF, 80/11, 80/22, FF/00]; the second 80 lands after its equal.
    add_row(OP_INSERT, 8'h80, 8'h11, 5'd0,  1, 1'b1, 1'b1, 8'h00, 8'h00, 5'd1);
    add_row(OP_INSERT, 8'h80, 8'h22, 5'h1F, 1, 1'b1, 1'b1, 8'h00, 8'h00, 5'd2);
    add_row(OP_INSERT, 8'h00, 8'hFF, 5'd0,  1, 1'b1, 1'b1, 8'h00, 8'h00, 5'd3);
    add_row(OP_INSERT, 8'hFF, 8'h00, 5'd0,  1, 1'b1, 1'b1, 8'h00, 8'h00, 5'd4);
    // Rank zero, rank count+1 and the widest rank fail.
    add_row(OP_READ,   8'h00, 8'h00, 5'd0,  1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd4);
    add_row(OP_READ,   8'h00, 8'h00, 5'd5,  1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd4);
    add_row(OP_READ,   8'h00, 8'h00, 5'h1F, 1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd4);
    add_row(OP_READ,   8'hFF, 8'hFF, 5'd1,  1, 1'b1, 1'b1, 8'h00, 8'hFF, 5'd4);
    add_row(OP_READ,   8'h00, 8'h00, 5'd2,  1, 1'b1, 1'b1, 8'h80, 8'h11, 5'd4);
    add_row(OP_READ,   8'h00, 8'h00, 5'd3,  1, 1'b1, 1'b1, 8'h80, 8'h22, 5'd4);
    add_row(OP_READ,   8'h00, 8'h00, 5'd4,  1, 1'b1, 1'b1, 8'hFF, 8'h00, 5'd4);
    add_row(OP_REMOVE, 8'h00, 8'h00, 5'd2,  1, 1'b1, 1'b1, 8'h00, 8'h00, 5'd3);
    add_row(OP_READ,   8'h00, 8'h00, 5'd2,  1, 1'b1, 1'b1, 8'h80, 8'h22, 5'd3);
    add_row(OP_REMOVE, 8'h00, 8'h00, 5'd0,  1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd3);
    // Fill to DEPTH with scattered keys, then overflow it.
    add_row(OP_INSERT, 8'h55, 8'hAA, 5'd0, 13, 1'b0, 1'b0, 8'h00, 8'h00, 5'd0);
    add_row(OP_INSERT, 8'h7F, 8'h7F, 5'd0,  1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd16);
    add_row(OP_READ,   8'h00, 8'h00, 5'd16, 1, 1'b0, 1'b0, 8'h00, 8'h00, 5'd0);
    add_row(OP_REMOVE, 8'h00, 8'h00, 5'd16, 1, 1'b0, 1'b0, 8'h00, 8'h00, 5'd0);
    add_row(OP_READ,   8'h00, 8'h00, 5'd16, 1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd15);
    add_row(OP_UNUSED, 8'hFF, 8'hFF, 5'd10, 1, 1'b1, 1'b0, 8'h00, 8'h00, 5'd15);

    // Hold reset, then release it on an edge.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table; repeated rows spread key and payload per pass.
    foreach (dir_rows[n]) begin
      for (int k = 0; k < dir_rows[n].reps; k++) begin
        r         = dir_rows[n].req;
        r.key     = r.key + KEY_BITS'(k * 29);
        r.payload = r.payload + PAYLOAD_BITS'(k * 7);
        offer(r, dir_rows[n].typed, dir_rows[n].want);
      end
    end

    // Random bursts: fill-heavy, drain-heavy or even mixes, each with a key
    // span that is narrow (many equal keys) or wide.
    sent       = 0;
    burst_left = 0;
    while (sent < RAND_REQS) begin
      if (burst_left == 0) begin
        mix        = mix_e'($urandom_range(2));
        burst_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       key_span = 3;
          1:       key_span = 15;
          default: key_span = 255;
        endcase
      end
      // Ask the result side for its long hold-off while requests keep coming.
      if (sent == 200) hold_asks++;
      // Pause the request side until every outstanding result has arrived.
      if (sent == 450) begin
        in_valid_i <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge clk_i);
      end
      // Run a stretch with no idling on either side.
      steady = (sent >= 600 && sent < 760);

      r.key = KEY_BITS'($urandom_range(key_span));
      if ($urandom_range(9) == 0) r.key = $urandom_range(1) ? 8'hFF : 8'h00;
      r.payload = PAYLOAD_BITS'($urandom_range(255));
      case ($urandom_range(9))
        0:       r.rank = '0;
        1:       r.rank = CNT_W'(list_count + 1);
        2:       r.rank = CNT_W'($urandom_range(31));
        default: r.rank = (list_count == 0) ? CNT_W'(1)
                                            : CNT_W'($urandom_range(list_count, 1));
      endcase
      pick = $urandom_range(99);
      if (pick < 3) begin
        r.opcode = OP_UNUSED;
      end else begin
        case (mix)
          MIX_FILL:  r.opcode = (pick < 75) ? OP_INSERT : (pick < 90) ? OP_READ : OP_REMOVE;
          MIX_DRAIN: r.opcode = (pick < 15) ? OP_INSERT : (pick < 40) ? OP_READ : OP_REMOVE;
          default:   r.opcode = (pick < 40) ? OP_INSERT : (pick < 70) ? OP_READ : OP_REMOVE;
        endcase
      end
      offer(r, 1'b0, none);
      sent++;
      burst_left--;
    end

    // Drop valid, drain the outstanding results, then watch for strays.
    in_valid_i <= 1'b0;
    steady = 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
